FILE: sv/gyi_pkg.sv
// shared types and constants for the gyro yaw integrator
// no dependencies; compiled first
`default_nettype none

package gyi_pkg;

  // request codes of the input item
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_RESET  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // configuration register indexes
  localparam logic [2:0]  CFG_BIAS_ENABLE    = 3'd0;
  localparam logic [2:0]  CFG_BIAS_ALPHA     = 3'd1;
  localparam logic [2:0]  CFG_QUIET_THRESH   = 3'd2;
  localparam logic [2:0]  CFG_SETTLE_TIME    = 3'd3;
  localparam logic [2:0]  CFG_STUCK_LIMIT    = 3'd4;
  localparam logic [2:0]  CFG_STAGNATION     = 3'd5;

  // ema gain of one in q1.16
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // a full turn is 5625 * 2^22 heading units
  localparam logic [12:0] TURN_ODD  = 13'd5625;
  localparam int          TURN_LOW  = 22;
  localparam logic signed [36:0] FULL_TURN = 37'sd23592960000;
  localparam logic signed [36:0] HALF_TURN = 37'sd11796480000;

  // remainder unit: 6 product bits per pass over the upper 42 bits
  localparam int         MOD_STEP = 6;
  localparam logic [2:0] MOD_LAST = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BMUL,
    S_BIAS,
    S_CORR,
    S_RMUL,
    S_MOD,
    S_ACC,
    S_FINISH
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RESET,
    OP_FIRST,
    OP_BACK,
    OP_PREP,
    OP_BMUL,
    OP_BIAS,
    OP_CORR,
    OP_RMUL,
    OP_MOD,
    OP_ACC,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sample;
    logic is_reset;
    logic have_ref;
    logic backward;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/gyi_in_if.sv
// input channel of the gyro yaw integrator: valid, ready and one item
// uses nothing but plain logic types
`default_nettype none

interface gyi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] gyro_rate;
  logic signed [34:0] reset_angle;
  logic [31:0]        item_time;

  modport source (output valid, req_type, gyro_rate, reset_angle, item_time,
                  input ready);
  modport sink   (input valid, req_type, gyro_rate, reset_angle, item_time,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/gyi_out_if.sv
// result channel of the gyro yaw integrator: valid, ready and one item
// uses nothing but plain logic types
`default_nettype none

interface gyi_out_if;
  logic               valid;
  logic               ready;
  logic signed [34:0] heading;
  logic signed [32:0] rate_corrected;
  logic signed [31:0] bias_estimate;
  logic               stuck;
  logic               referenced;

  modport source (output valid, heading, rate_corrected, bias_estimate, stuck,
                  referenced, input ready);
  modport sink   (input valid, heading, rate_corrected, bias_estimate, stuck,
                  referenced, output ready);
endinterface

`default_nettype wire

FILE: sv/gyi_cfg_if.sv
// configuration write channel: valid, ready, register index and data
// uses nothing but plain logic types
`default_nettype none

interface gyi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/gyi_ctrl.sv
// sequencer for the gyro yaw integrator: state machine, remainder pass count,
// result valid; depends on gyi_pkg
`default_nettype none

module gyi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  input  wire gyi_pkg::dp_status_t status,
  output gyi_pkg::dp_cmd_t         cmd
);
  import gyi_pkg::*;

  ctrl_state_t state, state_next;
  logic [2:0]  mod_cnt;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (state == S_MOD) begin
      mod_cnt <= mod_cnt + 3'd1;
    end else begin
      mod_cnt <= '0;
    end
  end

  // result register: refilled only once the previous item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == OP_LOAD_OUT) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.is_reset) begin
          cmd.op     = OP_RESET;
          state_next = S_FINISH;
        end else if (status.is_sample) begin
          if (!status.have_ref) begin
            cmd.op     = OP_FIRST;
            state_next = S_FINISH;
          end else if (status.backward) begin
            cmd.op     = OP_BACK;
            state_next = S_FINISH;
          end else begin
            cmd.op     = OP_PREP;
            state_next = S_BMUL;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_BMUL: begin
        cmd.op     = OP_BMUL;
        state_next = S_BIAS;
      end
      S_BIAS: begin
        cmd.op     = OP_BIAS;
        state_next = S_CORR;
      end
      S_CORR: begin
        cmd.op     = OP_CORR;
        state_next = S_RMUL;
      end
      S_RMUL: begin
        cmd.op     = OP_RMUL;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.op = OP_MOD;
        if (mod_cnt == MOD_LAST) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/gyi_datapath.sv
// datapath of the gyro yaw integrator: config and state registers, bias and
// rate multipliers, remainder unit, heading wrap, result register; uses gyi_pkg
`default_nettype none

module gyi_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gyi_pkg::dp_cmd_t    cmd,
  output gyi_pkg::dp_status_t      status,
  input  wire logic [1:0]          req_type,
  input  wire logic signed [31:0]  gyro_rate,
  input  wire logic signed [34:0]  reset_angle,
  input  wire logic [31:0]         item_time,
  input  wire logic                cfg_valid,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  output logic signed [34:0]       heading,
  output logic signed [32:0]       rate_corrected,
  output logic signed [31:0]       bias_estimate,
  output logic                     stuck,
  output logic                     referenced
);
  import gyi_pkg::*;

  // configuration
  logic        bias_enable;
  logic [16:0] bias_alpha;
  logic [30:0] quiet_threshold;
  logic [31:0] settle_time_ms;
  logic [30:0] stuck_rate_limit;
  logic [31:0] still_window;

  // tracked state
  logic               have_ref;
  logic signed [34:0] yaw;
  logic signed [32:0] last_corr;
  logic signed [31:0] bias;
  logic [31:0]        last_sample_time;
  logic [31:0]        last_motion_time;

  // captured item and work registers
  logic [1:0]         req_r;
  logic signed [31:0] rate_r;
  logic signed [34:0] angle_r;
  logic [31:0]        ts_r;
  logic               moving;
  logic               adapt;
  logic               delta_neg;
  logic [31:0]        delta_mag;
  logic               corr_neg;
  logic [31:0]        corr_mag;
  logic [63:0]        prod;
  logic [12:0]        mod_rem;

  // combinational helpers
  logic [31:0]        rate_mag;
  logic               moving_now;
  logic               settled;
  logic signed [32:0] rate_minus_bias;
  logic [32:0]        rmb_neg;
  logic [16:0]        alpha_sat;
  logic [48:0]        bias_round;
  logic [31:0]        bias_step;
  logic signed [33:0] bias_sum;
  logic [31:0]        dt;
  logic [12:0]        mod_rem_next;
  logic signed [36:0] inc;
  logic signed [36:0] yaw_sum;
  logic [32:0]        lc_neg;
  logic [31:0]        lc_mag;
  logic [31:0]        idle_ms;
  logic               stuck_now;

  function automatic logic signed [34:0] wrap_turn(input logic signed [36:0] a);
    logic signed [36:0] r;
    begin
      r = a;
      if (a >= HALF_TURN) begin
        r = a - FULL_TURN;
      end else if (a < -HALF_TURN) begin
        r = a + FULL_TURN;
      end
      return r[34:0];
    end
  endfunction

  assign status.is_sample = (req_r == REQ_SAMPLE);
  assign status.is_reset  = (req_r == REQ_RESET);
  assign status.have_ref  = have_ref;
  assign status.backward  = (ts_r < last_sample_time);

  assign rate_mag        = rate_r[31] ? 32'(-rate_r) : 32'(rate_r);
  assign moving_now      = rate_mag > {1'b0, quiet_threshold};
  assign settled         = 32'(ts_r - last_motion_time) >= settle_time_ms;
  assign rate_minus_bias = 33'(rate_r) - 33'(bias);
  assign rmb_neg         = 33'(-rate_minus_bias);
  assign alpha_sat       = (bias_alpha > ALPHA_ONE) ? ALPHA_ONE : bias_alpha;
  assign bias_round      = prod[48:0] + 49'd32768;
  assign bias_step       = bias_round[47:16];
  assign bias_sum        = delta_neg ? (34'(bias) - 34'({2'b00, bias_step}))
                                     : (34'(bias) + 34'({2'b00, bias_step}));
  assign dt              = ts_r - last_sample_time;
  assign inc             = corr_neg ? -37'({2'b00, mod_rem, prod[TURN_LOW-1:0]})
                                    : 37'({2'b00, mod_rem, prod[TURN_LOW-1:0]});
  assign yaw_sum         = 37'(yaw) + inc;

  assign lc_neg    = 33'(-last_corr);
  assign lc_mag    = last_corr[32] ? lc_neg[31:0] : last_corr[31:0];
  assign idle_ms   = (ts_r >= last_motion_time) ? (ts_r - last_motion_time) : 32'd0;
  assign stuck_now = have_ref && (lc_mag <= {1'b0, stuck_rate_limit}) &&
                     (idle_ms >= still_window);

  // six restoring steps of the remainder by the odd part of a turn
  always_comb begin
    logic [13:0] t;
    logic [12:0] r;
    r = mod_rem;
    for (int i = 0; i < MOD_STEP; i++) begin
      t = {r, prod[63-i]};
      if (t >= {1'b0, TURN_ODD}) begin
        t = t - {1'b0, TURN_ODD};
      end
      r = t[12:0];
    end
    mod_rem_next = r;
  end

  // configuration and tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_enable      <= 1'b0;
      bias_alpha       <= '0;
      quiet_threshold  <= '0;
      settle_time_ms   <= '0;
      stuck_rate_limit <= '0;
      still_window     <= '0;
      have_ref         <= 1'b0;
      yaw              <= '0;
      last_corr        <= '0;
      bias             <= '0;
      last_sample_time <= '0;
      last_motion_time <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BIAS_ENABLE:  bias_enable      <= cfg_data[0];
          CFG_BIAS_ALPHA:   bias_alpha       <= cfg_data[16:0];
          CFG_QUIET_THRESH: quiet_threshold  <= cfg_data[30:0];
          CFG_SETTLE_TIME:  settle_time_ms   <= cfg_data;
          CFG_STUCK_LIMIT:  stuck_rate_limit <= cfg_data[30:0];
          CFG_STAGNATION:   still_window     <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_RESET: begin
          have_ref         <= 1'b0;
          yaw              <= wrap_turn(37'(angle_r));
          last_corr        <= '0;
          last_sample_time <= ts_r;
          last_motion_time <= ts_r;
        end
        OP_FIRST: begin
          have_ref         <= 1'b1;
          last_sample_time <= ts_r;
          last_corr        <= rate_minus_bias;
          if (moving_now) begin
            last_motion_time <= ts_r;
          end
        end
        OP_BACK: begin
          last_corr <= rate_minus_bias;
        end
        OP_BIAS: begin
          if (adapt) begin
            bias <= bias_sum[31:0];
          end
        end
        OP_CORR: begin
          last_corr <= rate_minus_bias;
        end
        OP_ACC: begin
          yaw              <= wrap_turn(yaw_sum);
          last_sample_time <= ts_r;
          if (moving) begin
            last_motion_time <= ts_r;
          end
        end
        default: ;
      endcase
    end
  end

  // item capture and work registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= req_type;
      rate_r  <= gyro_rate;
      angle_r <= reset_angle;
      ts_r    <= item_time;
    end
    case (cmd.op)
      OP_PREP: begin
        moving    <= moving_now;
        adapt     <= bias_enable && !moving_now && settled;
        delta_neg <= rate_minus_bias[32];
        delta_mag <= rate_minus_bias[32] ? rmb_neg[31:0] : rate_minus_bias[31:0];
      end
      OP_BMUL: begin
        prod <= 64'(alpha_sat * delta_mag);
      end
      OP_CORR: begin
        corr_neg <= rate_minus_bias[32];
        corr_mag <= rate_minus_bias[32] ? rmb_neg[31:0] : rate_minus_bias[31:0];
      end
      OP_RMUL: begin
        prod    <= corr_mag * dt;
        mod_rem <= '0;
      end
      OP_MOD: begin
        mod_rem        <= mod_rem_next;
        prod[63:TURN_LOW] <= {prod[63-MOD_STEP:TURN_LOW], {MOD_STEP{1'b0}}};
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_OUT) begin
      heading        <= yaw;
      rate_corrected <= last_corr;
      bias_estimate  <= bias;
      stuck          <= stuck_now;
      referenced     <= have_ref;
    end
  end

endmodule

`default_nettype wire

FILE: sv/gyro_yaw_integrator_bias_track.sv
// Gyro yaw integrator with exponential bias tracking. One item is taken at a
// time: req.ready is high only while the sequencer is idle, and the result
// register lets the next item in while a result still waits on rsp. A reset,
// a stuck query, an unused code or a sample that only records its rate
// (first after a reset, or earlier than the last one) skips the multiplies.
// An integrating sample runs two registered multiplies (bias gain, then rate
// times elapsed ms) and seven passes of the remainder unit that reduces the
// 64-bit increment modulo a full turn, six bits per pass. Config writes are
// always ready and must only be issued while the block is idle.
// Depends on gyi_pkg, the three channel interfaces, gyi_ctrl and gyi_datapath.
`default_nettype none

module gyro_yaw_integrator_bias_track (
  input  wire logic clk,
  input  wire logic rst,
  gyi_in_if.sink    req,
  gyi_out_if.source rsp,
  gyi_cfg_if.sink   cfg
);
  import gyi_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg.ready = 1'b1;

  gyi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gyi_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .req_type       (req.req_type),
    .gyro_rate      (req.gyro_rate),
    .reset_angle    (req.reset_angle),
    .item_time      (req.item_time),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .heading        (rsp.heading),
    .rate_corrected (rsp.rate_corrected),
    .bias_estimate  (rsp.bias_estimate),
    .stuck          (rsp.stuck),
    .referenced     (rsp.referenced)
  );

endmodule

`default_nettype wire

FILE: sv/gyi_checker.sv
// port-level checks for the gyro yaw integrator, bound to the top level
// depends on gyi_pkg and gyro_yaw_integrator_bias_track
`default_nettype none

module gyi_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic signed [34:0] heading,
  input wire logic               stuck,
  input wire logic               referenced
);
  import gyi_pkg::*;

  // result register comes out of reset empty
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // one item in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("input taken again while an item is at work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(heading)))
    else $error("stalled result changed or dropped");

  a_stuck_needs_ref: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!stuck || referenced))
    else $error("stuck flag without a reference");

  a_heading_wrapped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((37'(heading) >= -HALF_TURN) && (37'(heading) < HALF_TURN)))
    else $error("heading outside half a turn");

endmodule

bind gyro_yaw_integrator_bias_track gyi_checker u_gyi_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .heading    (rsp.heading),
  .stuck      (rsp.stuck),
  .referenced (rsp.referenced)
);

`default_nettype wire

FILE: test/gyi_yaw_checker.sv
// result checker for the gyro yaw integrator: watches the item, result and register
// channels, predicts heading, corrected rate, bias and stuck flag, and counts mismatches
// depends on gyi_pkg and the three channel interfaces
`timescale 1ns / 100ps

module gyi_yaw_checker (
  input  logic clk,
  input  logic rst,
  gyi_in_if    req,
  gyi_out_if   rsp,
  gyi_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding,
  output int   results_checked,
  output int   bias_steps
);
  import gyi_pkg::*;

  localparam longint TURN = longint'(FULL_TURN);
  localparam longint HALF = longint'(HALF_TURN);
  localparam logic [63:0] TURN_U = 64'(FULL_TURN);

  typedef struct packed {
    logic signed [34:0] heading;
    logic signed [32:0] rate_corrected;
    logic signed [31:0] bias_estimate;
    logic               stuck;
    logic               referenced;
  } yaw_result_t;

  yaw_result_t results_due[$];

  // register copy
  logic        bias_en;
  logic [16:0] alpha;
  logic [30:0] quiet_lim;
  logic [31:0] settle;
  logic [30:0] stuck_lim;
  logic [31:0] stag;

  // integrator state
  bit          have_ref;
  longint      yaw;
  longint      corr_last;
  longint      bias;
  logic [31:0] t_sample;
  logic [31:0] t_motion;

  function automatic logic [63:0] abs64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint fold_heading(longint a);
    longint r;
    r = a % TURN;
    if (r < -HALF) r += TURN;
    else if (r >= HALF) r -= TURN;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
  endtask

  task automatic advance_heading(input logic [1:0] kind, input logic signed [31:0] rate_in,
                                 input logic signed [34:0] angle_in, input logic [31:0] ts,
                                 output yaw_result_t r);
    longint      rate;
    longint      delta;
    longint      corr_now;
    logic [63:0] step;
    logic [63:0] inc;
    logic [31:0] dt;
    logic [31:0] idle;
    logic [16:0] gain;
    bit          moving;
    rate = longint'(rate_in);
    moving = abs64(rate) > {33'd0, quiet_lim};
    if (kind == REQ_RESET) begin
      have_ref = 1'b0;
      yaw = fold_heading(longint'(angle_in));
      corr_last = 0;
      t_sample = ts;
      t_motion = ts;
    end else if (kind == REQ_SAMPLE) begin
      if (have_ref && ts < t_sample) begin
        // late sample: rate only
        corr_last = rate - bias;
      end else if (!have_ref) begin
        have_ref = 1'b1;
        t_sample = ts;
        corr_last = rate - bias;
        if (moving) t_motion = ts;
      end else begin
        dt = ts - t_sample;
        if (bias_en && !moving && (ts - t_motion) >= settle) begin
          gain = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
          delta = rate - bias;
          step = (64'(gain) * abs64(delta) + 64'd32768) >> 16;
          bias = (delta < 0) ? bias - longint'(step) : bias + longint'(step);
          bias_steps++;
        end
        corr_now = rate - bias;
        inc = (abs64(corr_now) * {32'd0, dt}) % TURN_U;
        yaw = fold_heading(yaw + ((corr_now < 0) ? -longint'(inc) : longint'(inc)));
        corr_last = corr_now;
        t_sample = ts;
        if (moving) t_motion = ts;
      end
    end
    r.heading = yaw[34:0];
    r.rate_corrected = corr_last[32:0];
    r.bias_estimate = bias[31:0];
    r.referenced = have_ref;
    if (!have_ref || abs64(corr_last) > {33'd0, stuck_lim}) begin
      r.stuck = 1'b0;
    end else begin
      idle = (ts >= t_motion) ? ts - t_motion : 32'd0;
      r.stuck = idle >= stag;
    end
  endtask

  always @(posedge clk) begin
    yaw_result_t want;
    if (rst) begin
      bias_en = 1'b0;
      alpha = '0;
      quiet_lim = '0;
      settle = '0;
      stuck_lim = '0;
      stag = '0;
      have_ref = 1'b0;
      yaw = 0;
      corr_last = 0;
      bias = 0;
      t_sample = '0;
      t_motion = '0;
      results_due.delete();
      mismatches = 0;
      results_checked = 0;
      bias_steps = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          CFG_BIAS_ENABLE:  bias_en = cfg.data[0];
          CFG_BIAS_ALPHA:   alpha = cfg.data[16:0];
          CFG_QUIET_THRESH: quiet_lim = cfg.data[30:0];
          CFG_SETTLE_TIME:  settle = cfg.data;
          CFG_STUCK_LIMIT:  stuck_lim = cfg.data[30:0];
          CFG_STAGNATION:   stag = cfg.data;
          default: ;
        endcase
      end
      // results leave before the item taken at the same edge is predicted
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, heading", 64'(rsp.heading), 64'd0);
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (rsp.heading !== want.heading)
            report_mismatch("heading", 64'(rsp.heading), 64'(want.heading));
          if (rsp.rate_corrected !== want.rate_corrected)
            report_mismatch("rate_corrected", 64'(rsp.rate_corrected),
                            64'(want.rate_corrected));
          if (rsp.bias_estimate !== want.bias_estimate)
            report_mismatch("bias_estimate", 64'(rsp.bias_estimate),
                            64'(want.bias_estimate));
          if (rsp.stuck !== want.stuck)
            report_mismatch("stuck", 64'(rsp.stuck), 64'(want.stuck));
          if (rsp.referenced !== want.referenced)
            report_mismatch("referenced", 64'(rsp.referenced), 64'(want.referenced));
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        advance_heading(req.req_type, req.gyro_rate, req.reset_angle, req.item_time,
                        want);
        results_due.push_back(want);
      end
    end
    outstanding = results_due.size();
  end

endmodule

FILE: test/gyro_yaw_integrator_bias_track_test.sv
// top of the yaw integrator testbench: clock, reset, register settings, directed and
// random items with random stalls on both channels, and the verdict
// depends on gyi_pkg, the channel interfaces, the block and gyi_yaw_checker
`timescale 1ns / 100ps

module gyro_yaw_integrator_bias_track_test;
  import gyi_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int STALL_PCT = 34;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 210;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   no_stall = 1'b0;

  int mismatches;
  int outstanding;
  int results_checked;
  int bias_steps;
  int items_sent = 0;

  logic [31:0] now_ms;
  logic [30:0] quiet_lim;
  int          drift;

  gyi_in_if  req_ch ();
  gyi_out_if rsp_ch ();
  gyi_cfg_if cfg_ch ();

  gyro_yaw_integrator_bias_track u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  gyi_yaw_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .req             (req_ch),
    .rsp             (rsp_ch),
    .cfg             (cfg_ch),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .bias_steps      (bias_steps)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    rsp_ch.ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
  end

  task automatic send_item(input logic [1:0] kind, input logic [31:0] rate,
                           input logic [34:0] angle, input logic [31:0] ts);
    @(negedge clk);
    while (!no_stall && $urandom_range(99) < STALL_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= kind;
    req_ch.gyro_rate    <= rate;
    req_ch.reset_angle  <= angle;
    req_ch.item_time    <= ts;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained;
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic configure_phase(input int p);
    logic [31:0] en, gain, quiet, settle, lim, stag;
    case (p)
      1: begin
        en = 0; gain = 0; quiet = 0; settle = 0; lim = 0; stag = 0;
      end
      2: begin
        // upper data bits beyond the register width are dropped
        en = 32'hFFFF_FFFF; gain = 32'd65536; quiet = 32'hFFFF_FFFF;
        settle = 0; lim = 32'h7FFF_FFFF; stag = 0;
      end
      4: begin
        en = 1; gain = 32'h1_FFFF; quiet = 32'h4000;
        settle = 32'hFFFF_FFFF; lim = 32'h4000; stag = 32'hFFFF_FFFF;
      end
      5: begin
        en = 0; gain = 1; quiet = $urandom_range(32'h10_0000);
        settle = 5; lim = $urandom_range(32'h10_0000); stag = 10;
      end
      3, 6: begin
        en = 1; gain = $urandom_range(65535, 1); quiet = $urandom_range(32'h10_0000);
        settle = $urandom_range(20); lim = $urandom_range(32'h10_0000);
        stag = $urandom_range(40);
      end
      default: begin
        en = 1; gain = 32768; quiet = 32'h1_0000; settle = 10; lim = 32'h8000; stag = 50;
      end
    endcase
    write_reg(CFG_BIAS_ENABLE, en);
    write_reg(CFG_BIAS_ALPHA, gain);
    write_reg(CFG_QUIET_THRESH, quiet);
    write_reg(CFG_SETTLE_TIME, settle);
    write_reg(CFG_STUCK_LIMIT, lim);
    write_reg(CFG_STAGNATION, stag);
    quiet_lim = quiet[30:0];
    drift = int'($urandom_range(4000)) - 2000;
  endtask

  function automatic logic [31:0] pick_rate();
    logic [31:0] edge_rate;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return drift + $urandom_range(1023) - 512;
      6, 7: return $urandom;
      8: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        // right at or just past the quiet limit
        edge_rate = {1'b0, quiet_lim} + $urandom_range(1);
        return $urandom_range(1) ? edge_rate : -edge_rate;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(19))
      0: return 32'd0;
      1: return $urandom;
      2, 3: return $urandom_range(10000, 100);
      default: return $urandom_range(6, 1);
    endcase
  endfunction

  task automatic random_item;
    int          pick;
    logic [34:0] angle;
    logic [1:0]  kind;
    logic [31:0] ts;
    pick = $urandom_range(99);
    angle = 35'({$urandom, $urandom});
    if (pick < 66) begin
      now_ms += pick_step();
      send_item(REQ_SAMPLE, pick_rate(), angle, now_ms);
    end else if (pick < 74) begin
      ts = $urandom_range(3) == 0 ? now_ms - $urandom_range(50) : now_ms + pick_step();
      send_item(REQ_QUERY, $urandom, angle, ts);
    end else if (pick < 80) begin
      send_item(REQ_RESET, $urandom, angle, now_ms);
    end else if (pick < 88) begin
      send_item(REQ_SAMPLE, pick_rate(), angle, now_ms - $urandom_range(200, 1));
    end else if (pick < 93) begin
      send_item(REQ_UNUSED, $urandom, angle, now_ms + $urandom_range(100));
    end else begin
      kind = 2'($urandom_range(3));
      ts = $urandom;
      if (kind == REQ_SAMPLE || kind == REQ_RESET) now_ms = ts;
      send_item(kind, $urandom, angle, ts);
    end
  endtask

  initial begin
    req_ch.valid        = 1'b0;
    req_ch.req_type     = REQ_QUERY;
    req_ch.gyro_rate    = '0;
    req_ch.reset_angle  = '0;
    req_ch.item_time    = '0;
    rsp_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_BIAS_ENABLE;
    cfg_ch.data         = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure_phase(0);
    send_item(REQ_QUERY, 32'h0, 35'h0, 32'd0);                 // no reference yet
    send_item(REQ_SAMPLE, 32'h0, 35'h0, 32'd100);              // first sample only records
    send_item(REQ_SAMPLE, 32'h7FFF_FFFF, 35'h0, 32'd200);
    send_item(REQ_SAMPLE, 32'h8000_0000, 35'h0, 32'd1200);
    send_item(REQ_SAMPLE, 32'd5, 35'h0, 32'd150);              // back in time
    send_item(REQ_SAMPLE, 32'd100, 35'h0, 32'd1300);           // quiet and settled
    send_item(REQ_SAMPLE, 32'hFFFF_FF9C, 35'h0, 32'd1304);
    send_item(REQ_SAMPLE, 32'h0001_0000, 35'h0, 32'd1305);     // exactly at quiet limit
    send_item(REQ_SAMPLE, 32'd20, 35'h0, 32'd1306);
    send_item(REQ_QUERY, 32'h0, 35'h0, 32'd1400);
    send_item(REQ_QUERY, 32'h0, 35'h0, 32'd1000);              // earlier than last motion
    send_item(REQ_UNUSED, 32'hFFFF_FFFF, 35'h7_FFFF_FFFF, 32'd2000);
    send_item(REQ_RESET, 32'h0, 35'h3_FFFF_FFFF, 32'd3000);    // out-of-range angles wrap
    send_item(REQ_RESET, 32'h0, 35'h4_0000_0000, 32'd3001);
    send_item(REQ_RESET, 32'h0, 35'(-HALF_TURN), 32'd3002);
    send_item(REQ_RESET, 32'h0, 35'(HALF_TURN - 37'sd1), 32'd3003);
    send_item(REQ_SAMPLE, 32'h0001_0000, 35'h0, 32'd3003);
    send_item(REQ_SAMPLE, 32'hFFFF_FFFF, 35'h0, 32'hFFFF_FFFF); // longest step
    send_item(REQ_SAMPLE, 32'd7, 35'h0, 32'd0);
    send_item(REQ_SAMPLE, 32'h0, 35'h0, 32'hFFFF_FFFF);        // zero elapsed
    send_item(REQ_QUERY, 32'h0, 35'h0, 32'hFFFF_FFFF);
    send_item(REQ_RESET, 32'h0, 35'h0, 32'hFFFF_FFF0);
    send_item(REQ_SAMPLE, 32'h0001_2345, 35'h0, 32'hFFFF_FFF0);
    send_item(REQ_SAMPLE, 32'h0000_0010, 35'h0, 32'hFFFF_FFF8);
    now_ms = 32'hFFFF_FFF8;

    for (int phase = 1; phase <= PHASES; phase++) begin
      wait_drained();
      no_stall = (phase == 2);
      configure_phase(phase);
      repeat (ITEMS_PER_PHASE) random_item();
    end
    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d items under %0d register settings, %0d results checked",
             items_sent, PHASES + 1, results_checked);
    $display("bias estimate stepped %0d times; %0d mismatches", bias_steps, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
